// ----- rtl/wpbn_pkg.sv -----
// Package for the noise generator: item types, register indexes, filter constants.
// Depends on nothing; used by every module in the rtl folder.
package wpbn_pkg;

  typedef struct packed {
    logic restart;
    logic block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               block_last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] index;
    logic [31:0] data;
  } cfg_item_t;

  localparam logic [1:0] REG_KIND  = 2'd0;
  localparam logic [1:0] REG_SEED  = 2'd1;
  localparam logic [1:0] REG_LEVEL = 2'd2;

  localparam logic [1:0] KIND_WHITE = 2'd0;
  localparam logic [1:0] KIND_PINK  = 2'd1;
  localparam logic [1:0] KIND_BROWN = 2'd2;

  localparam logic [31:0] GOLDEN_SEED = 32'h9E3779B9;
  localparam int PINK_STAGE_COUNT_DEF = 6;

  localparam logic signed [21:0] PINK_NORM  = 22'sd200000;
  localparam logic signed [21:0] BROWN_POLE = 22'sd1046446;
  localparam logic signed [21:0] BROWN_FEED = 22'sd2130;
  localparam logic signed [21:0] BROWN_GAIN = 22'sd360000;
  localparam logic signed [21:0] DCB_R      = 22'sd32604;
  localparam logic signed [21:0] DIRECT_TAP = 22'sd121569;

  function automatic logic signed [21:0] pole_coef(input logic [2:0] i);
    logic signed [21:0] r;
    begin
      unique case (i)
        3'd0: r = 22'sd1047658;
        3'd1: r = 22'sd1041827;
        3'd2: r = 22'sd1016095;
        3'd3: r = 22'sd908735;
        3'd4: r = 22'sd576716;
        default: r = -22'sd798570;
      endcase
      return r;
    end
  endfunction

  function automatic logic signed [21:0] feed_coef(input logic [2:0] i);
    logic signed [21:0] r;
    begin
      unique case (i)
        3'd0: r = 22'sd58222;
        3'd1: r = 22'sd78733;
        3'd2: r = 22'sd161332;
        3'd3: r = 22'sd325583;
        3'd4: r = 22'sd558893;
        default: r = -22'sd17720;
      endcase
      return r;
    end
  endfunction

endpackage

// ----- rtl/wpbn_serial_mul.sv -----
// Bit-serial signed multiplier: 32-bit operand times 22-bit coefficient, one bit per cycle.
// Imports wpbn_pkg but uses none of it; result is the full 54-bit product.
module wpbn_serial_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] a,
  input  logic signed [21:0] b,
  output logic               done,
  output logic signed [53:0] product
);
  import wpbn_pkg::*;

  logic [21:0]        mult;
  logic signed [53:0] mcand;
  logic signed [53:0] acc;
  logic [4:0]         count;
  logic               busy;

  assign product = acc;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      mult  <= b;
      mcand <= 54'(a);
      acc   <= '0;
      count <= '0;
    end else if (busy) begin
      if (mult[0]) begin
        if (count == 5'd21) begin
          acc <= acc - mcand;
        end else begin
          acc <= acc + mcand;
        end
      end
      mult  <= mult >> 1;
      mcand <= mcand <<< 1;
      count <= count + 5'd1;
      if (count == 5'd21) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("multiplier done while busy");
  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("multiplier did not start");
  assert property (@(posedge clk) disable iff (rst) busy |-> count <= 5'd21)
    else $error("multiplier count overrun");
endmodule

// ----- rtl/wpbn_core.sv -----
// Sequencer of the noise generator: xorshift, pink, brown, DC blocker and level scaling.
// Uses wpbn_pkg and wpbn_serial_mul; brown feed and gain factor bypass the shared unit.
module wpbn_core #(
  parameter int PINK_STAGES = wpbn_pkg::PINK_STAGE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  wpbn_pkg::in_item_t item,
  input  logic [1:0]        kind,
  input  logic [31:0]       seed,
  input  logic [6:0]        level,
  output logic              done,
  output wpbn_pkg::out_item_t result
);
  import wpbn_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RNG   = 10'b0000000010,
    S_PDEC  = 10'b0000000100,
    S_PFEED = 10'b0000001000,
    S_PTAP  = 10'b0000010000,
    S_PNORM = 10'b0000100000,
    S_BPOLE = 10'b0001000000,
    S_BGAIN = 10'b0010000000,
    S_DCB   = 10'b0100000000,
    S_GAIN  = 10'b1000000000
  } state_t;

  localparam int IW = (PINK_STAGES > 1) ? $clog2(PINK_STAGES) : 1;

  // The level gain level*32768/100 is a multiply by 327.68 scaled by 2^12 and
  // rounded up, followed by a shift; this is exact for levels up to 100.
  localparam logic [27:0] LEVEL_RECIP = 28'd1342178;

  state_t state;
  logic [31:0] rng;
  logic signed [31:0] pink [PINK_STAGES];
  logic signed [15:0] brown;
  logic signed [23:0] dcb_in;
  logic signed [31:0] dcb_out;
  logic signed [15:0] white;
  logic signed [15:0] s;
  logic signed [39:0] sum;
  logic signed [31:0] decay;
  logic signed [39:0] bacc;
  logic [IW-1:0] idx;
  logic blk;
  logic wait_mul;

  logic               mstart;
  logic signed [31:0] ma;
  logic signed [21:0] mb;
  logic               mdone;
  logic signed [53:0] mp;

  wpbn_serial_mul u_mul (
    .clk(clk), .rst(rst), .start(mstart), .a(ma), .b(mb), .done(mdone), .product(mp)
  );

  logic [31:0] x0, x1, x2, x3;
  logic signed [17:0] wd;
  logic signed [33:0] p20;
  logic signed [38:0] p15;
  logic signed [31:0] dcb_sum;
  logic signed [31:0] stage_next;
  logic [6:0] pct;
  logic [27:0] gain_prod;
  logic [15:0] gain;

  function automatic logic signed [15:0] clamp_s(input logic signed [53:0] v,
                                                  input logic signed [17:0] lo);
    logic signed [15:0] r;
    begin
      if (v < 54'(lo)) r = 16'(lo);
      else if (v > 54'sd32767) r = 16'sd32767;
      else r = v[15:0];
      return r;
    end
  endfunction

  always_comb begin
    x0 = (rng == '0) ? GOLDEN_SEED : rng;
    x1 = x0 ^ (x0 << 13);
    x2 = x1 ^ (x1 >> 17);
    x3 = x2 ^ (x2 << 5);
    wd = 18'($signed({2'b00, x3[31:16]})) - 18'sd32768;
    p20 = mp[53:20];
    p15 = mp[53:15];
    dcb_sum = dcb_out + 32'(s) * 32'sd256 - 32'(dcb_in);
    stage_next = decay + $signed(p20[31:0]);
    pct = (level > 7'd100) ? 7'd100 : level;
    gain_prod = 28'(pct) * LEVEL_RECIP;
    gain = gain_prod[27:12];
  end

  always_ff @(posedge clk) begin
    mstart <= 1'b0;
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      wait_mul <= 1'b0;
      rng <= GOLDEN_SEED;
      for (int i = 0; i < PINK_STAGES; i++) pink[i] <= '0;
      brown <= '0;
      dcb_in <= '0;
      dcb_out <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            blk <= item.block_end;
            if (item.restart) begin
              rng <= (seed == '0) ? GOLDEN_SEED : seed;
              for (int i = 0; i < PINK_STAGES; i++) pink[i] <= '0;
              brown <= '0;
              dcb_in <= '0;
              dcb_out <= '0;
            end
            state <= S_RNG;
          end
        end
        S_RNG: begin
          rng <= x3;
          white <= (wd == -18'sd32768) ? -16'sd32767 : wd[15:0];
          idx <= '0;
          sum <= '0;
          wait_mul <= 1'b0;
          if (kind == KIND_PINK) state <= S_PDEC;
          else if (kind == KIND_BROWN) state <= S_BPOLE;
          else begin
            s <= (wd == -18'sd32768) ? -16'sd32767 : wd[15:0];
            state <= S_GAIN;
          end
        end
        S_PDEC: begin
          if (!wait_mul) begin
            ma <= pink[idx];
            mb <= pole_coef(3'(idx));
            mstart <= 1'b1;
            wait_mul <= 1'b1;
          end else if (mdone) begin
            decay <= p20[31:0];
            wait_mul <= 1'b0;
            state <= S_PFEED;
          end
        end
        S_PFEED: begin
          if (!wait_mul) begin
            ma <= 32'(white);
            mb <= feed_coef(3'(idx));
            mstart <= 1'b1;
            wait_mul <= 1'b1;
          end else if (mdone) begin
            pink[idx] <= stage_next;
            sum <= sum + 40'(stage_next);
            wait_mul <= 1'b0;
            if (32'(idx) == PINK_STAGES - 1) state <= S_PTAP;
            else begin
              idx <= idx + IW'(1);
              state <= S_PDEC;
            end
          end
        end
        S_PTAP: begin
          if (!wait_mul) begin
            ma <= 32'(white);
            mb <= DIRECT_TAP;
            mstart <= 1'b1;
            wait_mul <= 1'b1;
          end else if (mdone) begin
            sum <= sum + 40'(p20);
            wait_mul <= 1'b0;
            state <= S_PNORM;
          end
        end
        S_PNORM: begin
          if (!wait_mul) begin
            ma <= sum[31:0];
            mb <= PINK_NORM;
            mstart <= 1'b1;
            wait_mul <= 1'b1;
          end else if (mdone) begin
            s <= clamp_s(54'($signed(p20[31:0])), -18'sd32767);
            wait_mul <= 1'b0;
            state <= S_DCB;
          end
        end
        S_BPOLE: begin
          if (!wait_mul) begin
            ma <= 32'(brown);
            mb <= BROWN_POLE;
            mstart <= 1'b1;
            wait_mul <= 1'b1;
            bacc <= 40'(white) * 40'(BROWN_FEED);
          end else if (mdone) begin
            brown <= clamp_s(54'((40'(mp) + bacc) >>> 20), -18'sd32767);
            wait_mul <= 1'b0;
            state <= S_BGAIN;
          end
        end
        S_BGAIN: begin
          if (!wait_mul) begin
            ma <= 32'(brown);
            mb <= BROWN_GAIN;
            mstart <= 1'b1;
            wait_mul <= 1'b1;
          end else if (mdone) begin
            s <= clamp_s(54'(p15), -18'sd32767);
            wait_mul <= 1'b0;
            state <= S_DCB;
          end
        end
        S_DCB: begin
          if (!wait_mul) begin
            ma <= dcb_sum;
            mb <= DCB_R;
            mstart <= 1'b1;
            wait_mul <= 1'b1;
          end else if (mdone) begin
            dcb_in <= 24'(32'(s) * 32'sd256);
            if (p15 > 39'sd1073741824) dcb_out <= 32'sd1073741824;
            else if (p15 < -39'sd1073741824) dcb_out <= -32'sd1073741824;
            else dcb_out <= p15[31:0];
            s <= clamp_s(54'(p15 >>> 8), -18'sd32767);
            wait_mul <= 1'b0;
            state <= S_GAIN;
          end
        end
        S_GAIN: begin
          if (!wait_mul) begin
            ma <= 32'(s);
            mb <= 22'($signed({1'b0, gain}));
            mstart <= 1'b1;
            wait_mul <= 1'b1;
          end else if (mdone) begin
            result.sample <= clamp_s(54'(p15), -18'sd32768);
            result.block_last <= blk;
            done <= 1'b1;
            wait_mul <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) done |-> state == S_IDLE)
    else $error("result produced outside idle");
  assert property (@(posedge clk) disable iff (rst) mstart |=> wait_mul)
    else $error("multiplier started without wait");
  assert property (@(posedge clk) disable iff (rst) (state == S_IDLE && start) |=> state == S_RNG)
    else $error("item not taken");
endmodule

// ----- rtl/white_pink_brown_noise_generator_top.sv -----
// Noise generator top level: handshakes, configuration registers, output register.
// One item is processed at a time; products other than the brown feed term and the level
// factor run on the shared bit-serial multiplier.
// A new item is taken once the previous result leaves the output register.
// Synchronous reset restores registers (white, golden seed, level 100) and clears filters.
module white_pink_brown_noise_generator_top #(
  parameter int PINK_STAGES = wpbn_pkg::PINK_STAGE_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  wpbn_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wpbn_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  wpbn_pkg::cfg_item_t cfg_data
);
  import wpbn_pkg::*;

  logic [1:0]  kind;
  logic [31:0] seed;
  logic [6:0]  level;
  logic        busy;
  logic        core_done;
  out_item_t   core_result;

  assign in_ready  = !busy && !out_valid || (!busy && out_ready);
  assign cfg_ready = 1'b1;

  wpbn_core #(.PINK_STAGES(PINK_STAGES)) u_core (
    .clk(clk), .rst(rst), .start(in_valid && in_ready), .item(in_data),
    .kind(kind), .seed(seed), .level(level), .done(core_done), .result(core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= KIND_WHITE;
      seed <= GOLDEN_SEED;
      level <= 7'd100;
      busy <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_data.index)
          REG_KIND:  kind <= cfg_data.data[1:0];
          REG_SEED:  seed <= cfg_data.data;
          REG_LEVEL: level <= cfg_data.data[6:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) busy <= 1'b1;
      else if (core_done) busy <= 1'b0;
      if (core_done) begin
        out_valid <= 1'b1;
        out_data <= core_result;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) core_done |-> busy)
    else $error("result without item");
  assert property (@(posedge clk) disable iff (rst) busy |-> !in_ready)
    else $error("input taken while busy");
  assert property (@(posedge clk) disable iff (rst) core_done |=> out_valid)
    else $error("result lost");
endmodule

// ----- verif/noise_checker.sv -----
// Checker for the noise generator: watches the input, output and register channels,
// predicts each noise sample and compares it field by field. Depends on wpbn_pkg.
module noise_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  wpbn_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  wpbn_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  wpbn_pkg::cfg_item_t cfg_data,
  output int                  fail_count,
  output int                  pending
);
  import wpbn_pkg::*;

  logic [1:0] kind;
  logic [31:0] seed;
  logic [6:0] level;
  logic [31:0] rng;
  longint pink [6];
  longint brown;
  longint dc_in;
  longint dc_out;
  out_item_t sample_queue[$];

  function automatic longint clampv(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint wrapv(longint v);
    logic signed [31:0] w;
    w = v[31:0];
    return longint'(w);
  endfunction

  function automatic longint hp_filter(longint x);
    longint xq, y;
    xq = x * 256;
    y = ((dc_out + xq - dc_in) * longint'(DCB_R)) >>> 15;
    dc_in = xq;
    dc_out = clampv(y, -(64'sd1 <<< 30), 64'sd1 <<< 30);
    return clampv(y >>> 8, -32767, 32767);
  endfunction

  function automatic out_item_t next_sample(in_item_t it);
    logic [31:0] x;
    longint w, s, sum, y, gain, pct;
    out_item_t r;
    if (it.restart) begin
      rng = (seed != 0) ? seed : GOLDEN_SEED;
      foreach (pink[i]) pink[i] = 0;
      brown = 0;
      dc_in = 0;
      dc_out = 0;
    end
    x = (rng == 0) ? GOLDEN_SEED : rng;
    x ^= x << 13;
    x ^= x >> 17;
    x ^= x << 5;
    rng = x;
    w = clampv(longint'(x[31:16]) - 32768, -32767, 32767);
    if (kind == KIND_PINK) begin
      sum = 0;
      for (int i = 0; i < 6; i++) begin
        pink[i] = wrapv(wrapv((longint'(pole_coef(3'(i))) * pink[i]) >>> 20)
                      + wrapv((longint'(feed_coef(3'(i))) * w) >>> 20));
        sum += pink[i];
      end
      sum += (longint'(DIRECT_TAP) * w) >>> 20;
      s = hp_filter(clampv(wrapv((sum * longint'(PINK_NORM)) >>> 20), -32767, 32767));
    end else if (kind == KIND_BROWN) begin
      y = brown * longint'(BROWN_POLE) + w * ((64'sd1 <<< 20) - longint'(BROWN_POLE));
      y = clampv(y >>> 20, -32767, 32767);
      brown = y;
      s = hp_filter(clampv((y * longint'(BROWN_GAIN)) >>> 15, -32767, 32767));
    end else begin
      s = w;
    end
    pct = (level > 100) ? 100 : level;
    gain = (pct * 32768) / 100;
    r.sample = 16'(clampv((s * gain) >>> 15, -32768, 32767));
    r.block_last = it.block_end;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_item;
    int errs;
    errs = 0;
    if (rst) begin
      kind <= KIND_WHITE;
      seed <= GOLDEN_SEED;
      level <= 7'd100;
      rng = GOLDEN_SEED;
      foreach (pink[i]) pink[i] = 0;
      brown = 0;
      dc_in = 0;
      dc_out = 0;
      sample_queue.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (sample_queue.size() == 0) begin
          $error("unexpected sample %0d", out_data.sample);
          errs++;
        end else begin
          exp_item = sample_queue.pop_front();
          if (exp_item.sample !== out_data.sample) begin
            $error("sample: expected %0d, actual %0d", exp_item.sample, out_data.sample);
            errs++;
          end
          if (exp_item.block_last !== out_data.block_last) begin
            $error("block_last: expected %0b, actual %0b", exp_item.block_last,
                   out_data.block_last);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) begin
        sample_queue.push_back(next_sample(in_data));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_data.index)
          REG_KIND:  kind <= cfg_data.data[1:0];
          REG_SEED:  seed <= cfg_data.data;
          REG_LEVEL: level <= cfg_data.data[6:0];
          default: ;
        endcase
      end
      fail_count <= fail_count + errs;
      pending <= sample_queue.size();
    end
  end
endmodule

// ----- verif/testbench.sv -----
// Top of the noise generator testbench: clock, reset, register writes and sample
// requests with random gaps and stalls. Depends on wpbn_pkg, noise_checker and the top level.
module testbench;
  import wpbn_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_item_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  cfg_item_t cfg_data = '0;
  int fail_count;
  int pending;
  int cycle_count = 0;
  int burst_left = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  white_pink_brown_noise_generator_top dut (.*);

  noise_checker checker_inst (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    case ((cycle_count / 400) % 4)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 3) != 0);
      2: out_ready <= ($urandom_range(0, 1) != 0);
      default: out_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    cfg_data <= '{index: idx, data: value};
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic send_sample(logic restart, logic block_end);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 40)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_data <= '{restart: restart, block_end: block_end};
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic end_burst();
    burst_left = 0;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_sample(1'b0, 1'b0);
    send_sample(1'b0, 1'b1);
    send_sample(1'b1, 1'b0);
    end_burst();
    for (int k = 0; k < 4; k++) begin
      wait_idle();
      write_reg(REG_KIND, 32'(k));
      write_reg(REG_SEED, (k == 1) ? 32'h0 : 32'hFFFFFFFF);
      write_reg(REG_LEVEL, (k == 2) ? 32'd0 : 32'd127);
      write_reg(2'd3, 32'h5);
      send_sample(1'b1, 1'b1);
      for (int j = 0; j < 4; j++) send_sample(1'b0, j[0]);
      end_burst();
    end
    for (int p = 0; p < 9; p++) begin
      wait_idle();
      write_reg(REG_KIND, 32'($urandom_range(0, 3)));
      write_reg(REG_SEED, (p == 0) ? 32'h1 : $urandom);
      write_reg(REG_LEVEL, (p == 1) ? 32'd100 : 32'($urandom_range(0, 127)));
      for (int j = 0; j < 50; j++)
        send_sample($urandom_range(0, 24) == 0, $urandom_range(0, 1));
      end_burst();
    end
    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (fail_count == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end
endmodule

// ----- white_pink_brown_noise_generator_top.f -----
rtl/wpbn_pkg.sv
rtl/wpbn_serial_mul.sv
rtl/wpbn_core.sv
rtl/white_pink_brown_noise_generator_top.sv
verif/noise_checker.sv
verif/testbench.sv
